[design/s_curve_motion_profile_assert.svh]
// assertion macros for the s-curve motion profile generator
// expects clk and arst_n in the scope of each use
`ifndef S_CURVE_MOTION_PROFILE_ASSERT_SVH
`define S_CURVE_MOTION_PROFILE_ASSERT_SVH

// same-cycle implication, off during reset
`define SCMP_ASSERT_IMPLY(label, ant, con, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (con)) \
		else $error(msg);

// next-cycle implication, off during reset
`define SCMP_ASSERT_NEXT(label, ant, con, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (con)) \
		else $error(msg);

`endif

[design/scmp_pkg.sv]
// shared widths, constants and types of the s-curve motion profile generator
// no dependencies
package scmp_pkg;

	localparam int TIME_BITS = 24;
	localparam int DATA_W    = 32;
	localparam int CFG_IDX_W = 1;
	localparam int T7_W      = TIME_BITS + 3;

	// restoring divider steps: local fraction and the two output quotients
	localparam int SIG_STEPS = 32;
	localparam int DIV_STEPS = 62;

	// stages: input, segment, remainder, fraction steps, seven arithmetic stages,
	// quotient steps, output register
	localparam int LATENCY = 3 + SIG_STEPS + 7 + DIV_STEPS + 1;

	localparam logic [18:0] VEL_SCALE = 19'd437500;
	// 6125000000000 = 11962890625 * 2^9
	localparam logic [33:0] ACC_CONST = 34'd11962890625;
	localparam int          ACC_SHIFT = 9;
	// ceil(2^34 / 3), exact for dividends below 2^33
	localparam logic [32:0] RECIP3    = 33'd5726623062;

	localparam logic [31:0] ONE_Q31  = 32'h8000_0000;
	localparam logic [31:0] HALF_Q31 = 32'h4000_0000;

	localparam logic [CFG_IDX_W-1:0] CFG_DISTANCE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_DURATION = 1'b1;

	typedef enum logic [1:0] {
		CLS_ZERO   = 2'b00,
		CLS_ACTIVE = 2'b01,
		CLS_DONE   = 2'b10
	} cls_t;

endpackage

[design/s_curve_motion_profile.sv]
// top level of the seven-segment s-curve position, velocity and acceleration generator
// depends on scmp_pkg and s_curve_motion_profile_assert.svh
// a fully pipelined datapath of restoring divider steps and short multiplier stages

// A sample is accepted on any edge with start high (busy is always low), one per clock
// cycle without gaps, and its result appears at the end of the pipeline on result_valid
// for exactly one cycle with position_ref, velocity_ref, accel_ref and move_done. The
// receiver cannot stall the block, so the result must be taken in that cycle. Most stages
// are restoring division steps: 32 steps for the segment-local fraction and 62 steps for
// the velocity and acceleration quotients, one step per stage. The user must write
// move_distance and move_duration through the cfg channel (always ready) only while no
// sample is in flight; the block does not enforce this. No clearing pass follows reset.

`include "s_curve_motion_profile_assert.svh"

module s_curve_motion_profile (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic signed [scmp_pkg::TIME_BITS:0]   elapsed_time,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic        [scmp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic        [scmp_pkg::DATA_W-1:0]    cfg_data,
	output logic                                  result_valid,
	output logic signed [scmp_pkg::DATA_W-1:0]    position_ref,
	output logic signed [scmp_pkg::DATA_W-1:0]    velocity_ref,
	output logic signed [scmp_pkg::DATA_W-1:0]    accel_ref,
	output logic                                  move_done
);
	import scmp_pkg::*;

	localparam int VS_W = 51;   // |distance| * velocity scale
	localparam int NV_W = 85;   // velocity dividend
	localparam int NB_W = 97;   // acceleration dividend before the shift by ACC_SHIFT
	localparam int DSQ_W = 2 * TIME_BITS;

	// saturate a magnitude to 32-bit two's complement and apply the sign
	function automatic logic [DATA_W-1:0] sat_out(input logic [DATA_W-1:0] mag,
		input logic neg);
		logic [DATA_W-1:0] m;
		begin
			m = mag;
			if (neg) begin
				if (m > ONE_Q31) m = ONE_Q31;
				sat_out = ~m + 1'b1;
			end else begin
				if (m > ONE_Q31 - 1'b1) m = ONE_Q31 - 1'b1;
				sat_out = m;
			end
		end
	endfunction

	// ---------------------------------------------------------------- configuration
	logic [DATA_W-1:0]    dist_q;
	logic [TIME_BITS-1:0] dur_q;
	// derived from configuration every cycle, only used from the second stage on
	logic [T7_W-1:0]      dmul_q [7];
	logic [DSQ_W-1:0]     dsq_q;
	logic [DATA_W-1:0]    magd_q;
	logic                 dneg_q;
	logic [VS_W-1:0]      vscale_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_q <= '0;
			dur_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_DISTANCE: dist_q <= cfg_data;
				CFG_DURATION: dur_q  <= cfg_data[TIME_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < 7; j++) dmul_q[j] <= '0;
			dsq_q    <= '0;
			magd_q   <= '0;
			dneg_q   <= 1'b0;
			vscale_q <= '0;
		end else begin
			// segment boundaries j * duration
			for (int j = 0; j < 7; j++) dmul_q[j] <= T7_W'(dur_q) * T7_W'(j);
			dsq_q    <= DSQ_W'(dur_q) * DSQ_W'(dur_q);
			magd_q   <= dist_q[DATA_W-1] ? (~dist_q + 1'b1) : dist_q;
			dneg_q   <= dist_q[DATA_W-1];
			vscale_q <= VS_W'(magd_q) * VS_W'(VEL_SCALE);
		end
	end

	// ---------------------------------------------------------------- stage 1: classify
	logic                 accept;
	logic                 t_neg;
	logic [TIME_BITS-1:0] t_mag;
	cls_t                 cls_in;

	assign accept = start && !busy;
	assign t_neg  = elapsed_time[TIME_BITS];
	assign t_mag  = elapsed_time[TIME_BITS-1:0];

	always_comb begin
		if (dur_q == '0 || (!t_neg && t_mag >= dur_q)) cls_in = CLS_DONE;
		else if (t_neg || t_mag == '0)                  cls_in = CLS_ZERO;
		else                                             cls_in = CLS_ACTIVE;
	end

	logic            vld_s1;
	cls_t            cls_s1;
	logic [T7_W-1:0] t7_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else         vld_s1 <= accept;
	end

	always_ff @(posedge clk) begin
		cls_s1 <= cls_in;
		// seven times the elapsed time
		t7_s1  <= {t_mag, 3'b000} - T7_W'(t_mag);
	end

	// ---------------------------------------------------------------- stage 2: segment index
	logic [2:0] seg_cnt;

	always_comb begin
		seg_cnt = '0;
		// 7t - 1 >= j * T is 7t > j * T
		for (int j = 1; j < 7; j++) seg_cnt = seg_cnt + 3'(t7_s1 > dmul_q[j]);
	end

	logic            vld_s2;
	cls_t            cls_s2;
	logic [T7_W-1:0] t7_s2;
	logic [2:0]      k_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else         vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		cls_s2 <= cls_s1;
		t7_s2  <= t7_s1;
		k_s2   <= seg_cnt;
	end

	// ---------------------------------------------------------------- stage 3: remainder
	logic                 vld_s3;
	cls_t                 cls_s3;
	logic [2:0]           k_s3;
	logic [TIME_BITS-1:0] r_s3;
	logic [T7_W-1:0]      r_full;

	assign r_full = t7_s2 - dmul_q[k_s2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else         vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		cls_s3 <= cls_s2;
		k_s3   <= k_s2;
		// r lies in 1..T
		r_s3   <= r_full[TIME_BITS-1:0];
	end

	// ---------------------------------------------------------------- stages 4..35: fraction
	// sigma = floor(r * 2^31 / T), one quotient bit per stage
	logic                 sig_v_s4   [SIG_STEPS];
	cls_t                 sig_cls_s4 [SIG_STEPS];
	logic [2:0]           sig_k_s4   [SIG_STEPS];
	logic [TIME_BITS-1:0] sig_rem_s4 [SIG_STEPS];
	logic [SIG_STEPS-1:0] sig_quo_s4 [SIG_STEPS];

	for (genvar i = 0; i < SIG_STEPS; i++) begin : g_sig
		logic [TIME_BITS:0]   cur;
		logic [TIME_BITS:0]   diff;
		logic                 ge;
		logic                 pv;
		cls_t                 pcls;
		logic [2:0]           pk;
		logic [SIG_STEPS-1:0] pq;

		if (i == 0) begin : g_first
			// r may equal T, so the first bit compares r itself
			assign cur  = {1'b0, r_s3};
			assign pv   = vld_s3;
			assign pcls = cls_s3;
			assign pk   = k_s3;
			assign pq   = '0;
		end else begin : g_next
			assign cur  = {sig_rem_s4[i-1], 1'b0};
			assign pv   = sig_v_s4[i-1];
			assign pcls = sig_cls_s4[i-1];
			assign pk   = sig_k_s4[i-1];
			assign pq   = sig_quo_s4[i-1];
		end

		assign diff = cur - {1'b0, dur_q};
		assign ge   = cur >= {1'b0, dur_q};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sig_v_s4[i] <= 1'b0;
			else         sig_v_s4[i] <= pv;
		end

		always_ff @(posedge clk) begin
			sig_cls_s4[i] <= pcls;
			sig_k_s4[i]   <= pk;
			sig_rem_s4[i] <= ge ? diff[TIME_BITS-1:0] : cur[TIME_BITS-1:0];
			sig_quo_s4[i] <= {pq[SIG_STEPS-2:0], ge};
		end
	end

	// ---------------------------------------------------------------- stage 36: sigma squared
	logic [DATA_W-1:0]   sig_end;
	logic [2*DATA_W-1:0] sq_prod;

	assign sig_end = sig_quo_s4[SIG_STEPS-1];
	assign sq_prod = (2*DATA_W)'(sig_end) * (2*DATA_W)'(sig_end);

	logic              vld_s36;
	cls_t              cls_s36;
	logic [2:0]        k_s36;
	logic [DATA_W-1:0] sig_s36;
	logic [DATA_W-1:0] sq_s36;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s36 <= 1'b0;
		else         vld_s36 <= sig_v_s4[SIG_STEPS-1];
	end

	always_ff @(posedge clk) begin
		cls_s36 <= sig_cls_s4[SIG_STEPS-1];
		k_s36   <= sig_k_s4[SIG_STEPS-1];
		sig_s36 <= sig_end;
		sq_s36  <= sq_prod[62:31];
	end

	// ---------------------------------------------------------------- stage 37: sigma cubed
	logic [2*DATA_W-1:0] cu_prod;

	assign cu_prod = (2*DATA_W)'(sq_s36) * (2*DATA_W)'(sig_s36);

	logic              vld_s37;
	cls_t              cls_s37;
	logic [2:0]        k_s37;
	logic [DATA_W-1:0] sig_s37;
	logic [DATA_W-1:0] sq_s37;
	logic [DATA_W-1:0] cu_s37;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s37 <= 1'b0;
		else         vld_s37 <= vld_s36;
	end

	always_ff @(posedge clk) begin
		cls_s37 <= cls_s36;
		k_s37   <= k_s36;
		sig_s37 <= sig_s36;
		sq_s37  <= sq_s36;
		cu_s37  <= cu_prod[62:31];
	end

	// ---------------------------------------------------------------- stage 38: segment polynomials
	// p is position * 48 / D, v is velocity * 16h / D, a is the normalised acceleration
	logic signed [39:0] ps, vs, as_;
	logic signed [39:0] s1v, s2v, s3v, onev;

	assign s1v  = $signed({8'b0, sig_s37});
	assign s2v  = $signed({8'b0, sq_s37});
	assign s3v  = $signed({8'b0, cu_s37});
	assign onev = $signed({8'b0, ONE_Q31});

	always_comb begin
		case (k_s37)
			3'd0: begin
				ps = s3v; vs = s2v; as_ = s1v;
			end
			3'd1: begin
				ps = onev + 3 * s1v + 3 * s2v; vs = onev + 2 * s1v; as_ = onev;
			end
			3'd2: begin
				ps  = 7 * onev + 9 * s1v + 3 * s2v - s3v;
				vs  = 3 * onev + 2 * s1v - s2v;
				as_ = onev - s1v;
			end
			3'd3: begin
				ps = 18 * onev + 12 * s1v; vs = 4 * onev; as_ = '0;
			end
			3'd4: begin
				ps = 30 * onev + 12 * s1v - s3v; vs = 4 * onev - s2v; as_ = -s1v;
			end
			3'd5: begin
				ps = 41 * onev + 9 * s1v - 3 * s2v; vs = 3 * onev - 2 * s1v; as_ = -onev;
			end
			default: begin
				ps  = 47 * onev + 3 * s1v - 3 * s2v + s3v;
				vs  = onev - 2 * s1v + s2v;
				as_ = s1v - onev;
			end
		endcase
	end

	logic               vld_s38;
	cls_t               cls_s38;
	logic signed [37:0] p_s38;
	logic signed [34:0] v_s38;
	logic signed [32:0] a_s38;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s38 <= 1'b0;
		else         vld_s38 <= vld_s37;
	end

	always_ff @(posedge clk) begin
		cls_s38 <= cls_s37;
		p_s38   <= ps[37:0];
		v_s38   <= vs[34:0];
		a_s38   <= as_[32:0];
	end

	// ---------------------------------------------------------------- stage 39: clamps, first products
	logic [37:0]         p_sum;
	logic [33:0]         v_pos;
	logic                a_neg;
	logic [32:0]         a_abs;
	logic [2*DATA_W-1:0] m_prod;

	assign p_sum  = p_s38[37] ? 38'd24 : ({1'b0, p_s38[36:0]} + 38'd24);
	assign v_pos  = v_s38[34] ? '0 : v_s38[33:0];
	assign a_neg  = a_s38[32];
	assign a_abs  = a_neg ? (~a_s38 + 1'b1) : a_s38;
	assign m_prod = (2*DATA_W)'(magd_q) * (2*DATA_W)'(a_abs[31:0]);

	logic        vld_s39;
	cls_t        cls_s39;
	logic        aneg_s39;
	logic [32:0] y_s39;
	logic [67:0] vpl_s39;
	logic [67:0] vph_s39;
	logic [62:0] m_s39;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s39 <= 1'b0;
		else         vld_s39 <= vld_s38;
	end

	always_ff @(posedge clk) begin
		cls_s39  <= cls_s38;
		aneg_s39 <= a_neg;
		// (p + 24) / 16, the division by 3 follows
		y_s39    <= p_sum[36:4];
		vpl_s39  <= 68'(vscale_q) * 68'(v_pos[16:0]);
		vph_s39  <= 68'(vscale_q) * 68'(v_pos[33:17]);
		m_s39    <= m_prod[62:0];
	end

	// ---------------------------------------------------------------- stage 40
	logic            vld_s40;
	cls_t            cls_s40;
	logic            aneg_s40;
	logic [65:0]     q3_s40;
	logic [NV_W-1:0] nv_s40;
	logic [65:0]     apl_s40;
	logic [64:0]     aph_s40;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s40 <= 1'b0;
		else         vld_s40 <= vld_s39;
	end

	always_ff @(posedge clk) begin
		cls_s40  <= cls_s39;
		aneg_s40 <= aneg_s39;
		q3_s40   <= 66'(y_s39) * 66'(RECIP3);
		nv_s40   <= NV_W'(vpl_s39) + {vph_s39, 17'b0};
		apl_s40  <= 66'(m_s39[31:0]) * 66'(ACC_CONST);
		aph_s40  <= 65'(m_s39[62:32]) * 65'(ACC_CONST);
	end

	// ---------------------------------------------------------------- stage 41
	logic [DATA_W-1:0] f_raw;

	assign f_raw = q3_s40[65:34];

	logic              vld_s41;
	cls_t              cls_s41;
	logic              aneg_s41;
	logic [DATA_W-1:0] f_s41;
	logic [NV_W-1:0]   nv_s41;
	logic [NB_W-1:0]   nb_s41;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s41 <= 1'b0;
		else         vld_s41 <= vld_s40;
	end

	always_ff @(posedge clk) begin
		cls_s41  <= cls_s40;
		aneg_s41 <= aneg_s40;
		f_s41    <= (f_raw > ONE_Q31) ? ONE_Q31 : f_raw;
		nv_s41   <= nv_s40;
		nb_s41   <= NB_W'(apl_s40) + {aph_s40, 32'b0};
	end

	// ---------------------------------------------------------------- stage 42: position, divider set-up
	logic [2*DATA_W-1:0]     pm_sum;
	logic [NV_W-DIV_STEPS-1:0] v_hi;
	logic [NB_W-DIV_STEPS+ACC_SHIFT-1:0] a_hi;

	assign pm_sum = (2*DATA_W)'(magd_q) * (2*DATA_W)'(f_s41) + (2*DATA_W)'(HALF_Q31);
	// bits of the quotient at 2^62 and up only decide saturation
	assign v_hi   = nv_s41[NV_W-1:DIV_STEPS];
	assign a_hi   = nb_s41[NB_W-1:DIV_STEPS-ACC_SHIFT];

	logic                 vld_s42;
	cls_t                 cls_s42;
	logic                 aneg_s42;
	logic [DATA_W-1:0]    pm_s42;
	logic                 vsat_s42;
	logic                 asat_s42;
	logic [TIME_BITS-1:0] vrem_s42;
	logic [DSQ_W-1:0]     arem_s42;
	logic [DIV_STEPS-1:0] vdq_s42;
	logic [DIV_STEPS-1:0] adq_s42;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s42 <= 1'b0;
		else         vld_s42 <= vld_s41;
	end

	always_ff @(posedge clk) begin
		cls_s42  <= cls_s41;
		aneg_s42 <= aneg_s41;
		pm_s42   <= pm_sum[62:31];
		vsat_s42 <= TIME_BITS'(v_hi) >= dur_q;
		asat_s42 <= DSQ_W'(a_hi) >= dsq_q;
		vrem_s42 <= TIME_BITS'(v_hi);
		arem_s42 <= DSQ_W'(a_hi);
		vdq_s42  <= nv_s41[DIV_STEPS-1:0];
		adq_s42  <= {nb_s41[DIV_STEPS-ACC_SHIFT-1:0], {ACC_SHIFT{1'b0}}};
	end

	// ---------------------------------------------------------------- stages 43..104: quotients
	// dividend bits shift out of the top of dq while quotient bits shift in
	logic                 dv_v_s43    [DIV_STEPS];
	cls_t                 dv_cls_s43  [DIV_STEPS];
	logic                 dv_aneg_s43 [DIV_STEPS];
	logic [DATA_W-1:0]    dv_pm_s43   [DIV_STEPS];
	logic                 dv_vsat_s43 [DIV_STEPS];
	logic                 dv_asat_s43 [DIV_STEPS];
	logic [TIME_BITS-1:0] dv_vrem_s43 [DIV_STEPS];
	logic [DSQ_W-1:0]     dv_arem_s43 [DIV_STEPS];
	logic [DIV_STEPS-1:0] dv_vdq_s43  [DIV_STEPS];
	logic [DIV_STEPS-1:0] dv_adq_s43  [DIV_STEPS];

	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
		logic                 pv, paneg, pvsat, pasat;
		cls_t                 pcls;
		logic [DATA_W-1:0]    ppm;
		logic [TIME_BITS-1:0] pvrem;
		logic [DSQ_W-1:0]     parem;
		logic [DIV_STEPS-1:0] pvdq, padq;
		logic [TIME_BITS:0]   vcur, vdiff;
		logic [DSQ_W:0]       acur, adiff;
		logic                 vge, age;

		if (i == 0) begin : g_first
			assign pv    = vld_s42;
			assign pcls  = cls_s42;
			assign paneg = aneg_s42;
			assign ppm   = pm_s42;
			assign pvsat = vsat_s42;
			assign pasat = asat_s42;
			assign pvrem = vrem_s42;
			assign parem = arem_s42;
			assign pvdq  = vdq_s42;
			assign padq  = adq_s42;
		end else begin : g_next
			assign pv    = dv_v_s43[i-1];
			assign pcls  = dv_cls_s43[i-1];
			assign paneg = dv_aneg_s43[i-1];
			assign ppm   = dv_pm_s43[i-1];
			assign pvsat = dv_vsat_s43[i-1];
			assign pasat = dv_asat_s43[i-1];
			assign pvrem = dv_vrem_s43[i-1];
			assign parem = dv_arem_s43[i-1];
			assign pvdq  = dv_vdq_s43[i-1];
			assign padq  = dv_adq_s43[i-1];
		end

		assign vcur  = {pvrem, pvdq[DIV_STEPS-1]};
		assign vdiff = vcur - {1'b0, dur_q};
		assign vge   = vcur >= {1'b0, dur_q};
		assign acur  = {parem, padq[DIV_STEPS-1]};
		assign adiff = acur - {1'b0, dsq_q};
		assign age   = acur >= {1'b0, dsq_q};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_v_s43[i] <= 1'b0;
			else         dv_v_s43[i] <= pv;
		end

		always_ff @(posedge clk) begin
			dv_cls_s43[i]  <= pcls;
			dv_aneg_s43[i] <= paneg;
			dv_pm_s43[i]   <= ppm;
			dv_vsat_s43[i] <= pvsat;
			dv_asat_s43[i] <= pasat;
			dv_vrem_s43[i] <= vge ? vdiff[TIME_BITS-1:0] : vcur[TIME_BITS-1:0];
			dv_arem_s43[i] <= age ? adiff[DSQ_W-1:0] : acur[DSQ_W-1:0];
			dv_vdq_s43[i]  <= {pvdq[DIV_STEPS-2:0], vge};
			dv_adq_s43[i]  <= {padq[DIV_STEPS-2:0], age};
		end
	end

	// ---------------------------------------------------------------- output register
	localparam int L = DIV_STEPS - 1;

	logic [DIV_STEPS:0] v_rnd, a_rnd;
	logic [DATA_W-1:0]  v_mag, a_mag;

	// round half up at 2^31; a quotient of 2^62 or more saturates
	assign v_rnd = (DIV_STEPS+1)'(dv_vdq_s43[L]) + (DIV_STEPS+1)'(HALF_Q31);
	assign a_rnd = (DIV_STEPS+1)'(dv_adq_s43[L]) + (DIV_STEPS+1)'(HALF_Q31);
	assign v_mag = dv_vsat_s43[L] ? ONE_Q31 : v_rnd[DIV_STEPS:31];
	assign a_mag = dv_asat_s43[L] ? ONE_Q31 : a_rnd[DIV_STEPS:31];

	logic              valid_q;
	logic [DATA_W-1:0] pos_q, vel_q, acc_q;
	logic              done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else         valid_q <= dv_v_s43[L];
	end

	always_ff @(posedge clk) begin
		case (dv_cls_s43[L])
			CLS_DONE: begin
				// finished move, or zero duration
				pos_q  <= dist_q;
				vel_q  <= '0;
				acc_q  <= '0;
				done_q <= 1'b1;
			end
			CLS_ACTIVE: begin
				pos_q  <= sat_out(dv_pm_s43[L], dneg_q);
				vel_q  <= sat_out(v_mag, dneg_q);
				acc_q  <= sat_out(a_mag, dneg_q ^ dv_aneg_s43[L]);
				done_q <= 1'b0;
			end
			default: begin
				// at or before time zero
				pos_q  <= '0;
				vel_q  <= '0;
				acc_q  <= '0;
				done_q <= 1'b0;
			end
		endcase
	end

	assign result_valid = valid_q;
	assign position_ref = pos_q;
	assign velocity_ref = vel_q;
	assign accel_ref    = acc_q;
	assign move_done    = done_q;

	// ---------------------------------------------------------------- assertions
	// every result goes back to exactly one accepted sample
	`SCMP_ASSERT_IMPLY(a_result_source, result_valid, $past(start, LATENCY),
		"result without an accepted sample")
	// the local fraction of a sample inside the move never passes one
	`SCMP_ASSERT_IMPLY(a_sigma_range,
		sig_v_s4[SIG_STEPS-1] && sig_cls_s4[SIG_STEPS-1] == CLS_ACTIVE,
		sig_quo_s4[SIG_STEPS-1] <= ONE_Q31, "local fraction above one")
	// first fraction step leaves a remainder below the duration
	`SCMP_ASSERT_NEXT(a_sigma_rem, vld_s3 && cls_s3 == CLS_ACTIVE,
		sig_rem_s4[0] < dur_q, "fraction remainder out of range")
	// a negative time with a non-zero duration gives an all-zero result
	`SCMP_ASSERT_IMPLY(a_negative_time,
		result_valid && $past(elapsed_time[TIME_BITS], LATENCY) && dur_q != '0,
		position_ref == '0 && velocity_ref == '0 && accel_ref == '0 && !move_done,
		"negative time gave a non-zero result")

endmodule
